FILE: rtl/pes_pkg.sv
// Package for the execute stage: operation kind codes, the packed issue and
// result item types, and the decode flag group passed from the ALU to the top.
// No dependencies.
package pes_pkg;

  localparam int unsigned XLEN = 64;

  typedef enum logic [3:0] {
    KIND_NOP  = 4'd0,
    KIND_ADD  = 4'd1,
    KIND_MUL  = 4'd2,
    KIND_CMP  = 4'd3,
    KIND_LDA  = 4'd4,
    KIND_LDC  = 4'd5,
    KIND_BEQ  = 4'd6,
    KIND_JMP  = 4'd7,
    KIND_JMPR = 4'd8,
    KIND_STA  = 4'd9
  } kind_e;

  typedef struct packed {
    logic [3:0]             kind;
    logic signed [XLEN-1:0] instr_pc;
    logic signed [XLEN-1:0] dest;
    logic signed [XLEN-1:0] operand_a;
    logic signed [XLEN-1:0] operand_b;
  } exec_in_t;

  typedef struct packed {
    logic [3:0]             out_kind;
    logic signed [XLEN-1:0] out_pc;
    logic signed [XLEN-1:0] out_dest;
    logic signed [XLEN-1:0] out_a;
    logic signed [XLEN-1:0] out_b;
    logic signed [XLEN-1:0] exec_value;
    logic                   taken;
    logic                   writeback;
  } exec_out_t;

  typedef struct packed {
    logic taken;
    logic writeback;
    logic use_mul;
  } exec_flags_t;

endpackage

FILE: rtl/pes_alu.sv
// Combinational ALU and decoder of the execute stage: everything except the
// multiply, computed at DATA_WIDTH bits. Depends on pes_pkg.
module pes_alu #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  pes_pkg::exec_in_t    item_i,
  output logic [DATA_WIDTH-1:0] value_o,
  output pes_pkg::exec_flags_t flags_o
);
  import pes_pkg::*;

  logic signed [DATA_WIDTH-1:0] wa;
  logic signed [DATA_WIDTH-1:0] wb;
  logic [DATA_WIDTH-1:0]        sum_ab;
  logic [DATA_WIDTH-1:0]        sum_store;
  logic [DATA_WIDTH-1:0]        pc_next;
  logic                         eq_ab;
  logic                         gt_ab;

  assign wa        = item_i.operand_a[DATA_WIDTH-1:0];
  assign wb        = item_i.operand_b[DATA_WIDTH-1:0];
  assign sum_ab    = wa + wb;
  assign sum_store = item_i.dest[DATA_WIDTH-1:0] + wb;
  assign pc_next   = item_i.instr_pc[DATA_WIDTH-1:0] + DATA_WIDTH'(1);
  assign eq_ab     = (wa == wb);
  assign gt_ab     = (wa > wb);

  always_comb begin
    value_o = '0;
    flags_o = '0;
    unique case (kind_e'(item_i.kind))
      KIND_ADD: begin
        value_o           = sum_ab;
        flags_o.writeback = 1'b1;
      end
      KIND_MUL: begin
        flags_o.use_mul   = 1'b1;
        flags_o.writeback = 1'b1;
      end
      KIND_CMP: begin
        if (eq_ab) begin
          value_o = '0;
        end else if (gt_ab) begin
          value_o = DATA_WIDTH'(1);
        end else begin
          value_o = '1;
        end
        flags_o.writeback = 1'b1;
      end
      KIND_LDA: begin
        value_o = sum_ab;
      end
      KIND_LDC: begin
        value_o           = wa;
        flags_o.writeback = 1'b1;
      end
      KIND_BEQ: begin
        if (eq_ab) begin
          value_o       = item_i.dest[DATA_WIDTH-1:0];
          flags_o.taken = 1'b1;
        end else begin
          value_o = pc_next;
        end
      end
      KIND_JMP: begin
        value_o       = wa;
        flags_o.taken = 1'b1;
      end
      KIND_JMPR: begin
        value_o       = sum_ab;
        flags_o.taken = 1'b1;
      end
      KIND_STA: begin
        value_o = sum_store;
      end
      default: begin
        value_o = '0;
        flags_o = '0;
      end
    endcase
  end

endmodule

FILE: rtl/pes_mul.sv
// Two-step wrapping multiplier: registered partial products of the operand
// halves, then one add that forms the low DATA_WIDTH bits. Depends on pes_pkg.
module pes_mul #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                  clk_i,
  input  logic [DATA_WIDTH-1:0] a_i,
  input  logic [DATA_WIDTH-1:0] b_i,
  output logic [DATA_WIDTH-1:0] prod_o
);
  import pes_pkg::*;

  localparam int unsigned HALF = (DATA_WIDTH + 1) / 2;
  localparam int unsigned HI_W = DATA_WIDTH - HALF;

  logic [HALF-1:0]   a_lo;
  logic [HALF-1:0]   b_lo;
  logic [HI_W-1:0]   a_hi;
  logic [HI_W-1:0]   b_hi;
  logic [2*HALF-1:0] pp_ll_d, pp_ll_q;
  logic [HI_W-1:0]   pp_ab_d, pp_ab_q;
  logic [HI_W-1:0]   pp_ba_d, pp_ba_q;

  assign a_lo = a_i[HALF-1:0];
  assign b_lo = b_i[HALF-1:0];
  assign a_hi = a_i[DATA_WIDTH-1:HALF];
  assign b_hi = b_i[DATA_WIDTH-1:HALF];

  // The cross terms land at bit HALF, so only their low HI_W bits survive.
  assign pp_ll_d = {{HALF{1'b0}}, a_lo} * {{HALF{1'b0}}, b_lo};
  assign pp_ab_d = a_lo[HI_W-1:0] * b_hi;
  assign pp_ba_d = a_hi * b_lo[HI_W-1:0];

  always_ff @(posedge clk_i) begin
    pp_ll_q <= pp_ll_d;
    pp_ab_q <= pp_ab_d;
    pp_ba_q <= pp_ba_d;
  end

  assign prod_o = pp_ll_q[DATA_WIDTH-1:0] + {pp_ab_q + pp_ba_q, {HALF{1'b0}}};

endmodule

FILE: rtl/pipeline_execute_stage_unit.sv
// Execute stage of an in-order processor, built from pes_alu and pes_mul.
// Depends on pes_pkg.
//
// The stage takes one instruction in every clock cycle: busy_o is always low,
// so a transfer happens at each edge where start_i is high. Each instruction
// gives exactly one result, shown on res_o for a single cycle with valid_o
// high once it has passed the input register, the stage-one register and
// the result register; the receiver cannot stall and must take it in that
// cycle. The multiplier registers its partial products alongside the
// stage-one register. Results leave in issue order. Arithmetic is done at
// DATA_WIDTH bits (8 to 64) and sign-extended to the 64-bit result fields.
module pipeline_execute_stage_unit #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  pes_pkg::exec_in_t  in_i,
  output logic               valid_o,
  output pes_pkg::exec_out_t res_o
);
  import pes_pkg::*;

  logic                  accept;
  logic                  in_vld_q;
  exec_in_t              in_q;
  logic                  s1_vld_q;
  exec_in_t              s1_q;
  logic [DATA_WIDTH-1:0] s1_val_q;
  exec_flags_t           s1_flags_q;
  logic [DATA_WIDTH-1:0] alu_val;
  exec_flags_t           alu_flags;
  logic [DATA_WIDTH-1:0] mul_prod;
  logic signed [DATA_WIDTH-1:0] s2_val;
  exec_out_t             res_d;
  exec_out_t             res_q;
  logic                  res_vld_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= accept;
      s1_vld_q  <= in_vld_q;
      res_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_i;
    end
  end

  pes_alu #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_alu (
    .item_i (in_q),
    .value_o(alu_val),
    .flags_o(alu_flags)
  );

  pes_mul #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (in_q.operand_a[DATA_WIDTH-1:0]),
    .b_i   (in_q.operand_b[DATA_WIDTH-1:0]),
    .prod_o(mul_prod)
  );

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      s1_q       <= in_q;
      s1_val_q   <= alu_val;
      s1_flags_q <= alu_flags;
    end
  end

  assign s2_val = s1_flags_q.use_mul ? mul_prod : s1_val_q;

  always_comb begin
    res_d            = '0;
    res_d.out_kind   = s1_q.kind;
    res_d.out_pc     = s1_q.instr_pc;
    res_d.out_dest   = s1_q.dest;
    res_d.out_a      = s1_q.operand_a;
    res_d.out_b      = s1_q.operand_b;
    res_d.exec_value = XLEN'(s2_val);
    res_d.taken      = s1_flags_q.taken;
    res_d.writeback  = s1_flags_q.writeback;
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      res_q <= res_d;
    end
  end

  assign valid_o = res_vld_q;
  assign res_o   = res_q;

`ifndef NO_ASSERTIONS
  // Every result strobe comes from a matching earlier transfer.
  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, 3))
    else $error("result strobe without a matching transfer");

  a_transfer_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##2 valid_o)
    else $error("transfer did not produce a result");

  a_taken_kinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && res_o.taken) |-> (res_o.out_kind == KIND_BEQ ||
      res_o.out_kind == KIND_JMP || res_o.out_kind == KIND_JMPR))
    else $error("taken flag on a kind that does not redirect");

  a_writeback_kinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && res_o.writeback) |-> (res_o.out_kind == KIND_ADD ||
      res_o.out_kind == KIND_MUL || res_o.out_kind == KIND_CMP ||
      res_o.out_kind == KIND_LDC))
    else $error("writeback flag on a kind without register result");

  a_nop_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (res_o.out_kind == KIND_NOP || res_o.out_kind > KIND_STA)) |->
      (res_o.exec_value == '0 && !res_o.taken && !res_o.writeback))
    else $error("nop result is not quiet");
`endif

endmodule

FILE: dv/pes_exec_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the execute stage: predicts each result from the issued
// instruction and compares it, field by field and in order, with the stage output.
// Depends on pes_pkg.
module pes_exec_checker #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  pes_pkg::exec_in_t  in_i,
  input  logic               valid_i,
  input  pes_pkg::exec_out_t res_i,
  output int                 pending_o,
  output int                 errors_o,
  output int                 checked_o
);

  import pes_pkg::*;

  localparam int unsigned MAX_PRINTED = 30;

  exec_out_t result_q[$];
  exec_out_t want;

  initial begin
    pending_o = 0;
    errors_o  = 0;
    checked_o = 0;
  end

  // Keep the low DATA_WIDTH bits and sign-extend them to 64 bits.
  function automatic logic [63:0] wrap_to_width(logic [63:0] v);
    logic signed [63:0] t;
    t = v << (64 - DATA_WIDTH);
    return t >>> (64 - DATA_WIDTH);
  endfunction

  function automatic exec_out_t execute_instr(exec_in_t it);
    exec_out_t   r;
    logic [63:0] a;
    logic [63:0] b;
    a = wrap_to_width(it.operand_a);
    b = wrap_to_width(it.operand_b);
    r = '0;
    r.out_kind = it.kind;
    r.out_pc   = it.instr_pc;
    r.out_dest = it.dest;
    r.out_a    = it.operand_a;
    r.out_b    = it.operand_b;
    case (it.kind)
      KIND_ADD: begin
        r.exec_value = wrap_to_width(a + b);
        r.writeback  = 1'b1;
      end
      KIND_MUL: begin
        r.exec_value = wrap_to_width(a * b);
        r.writeback  = 1'b1;
      end
      KIND_CMP: begin
        if (a == b) r.exec_value = '0;
        else if ($signed(a) > $signed(b)) r.exec_value = 64'd1;
        else r.exec_value = '1;
        r.writeback = 1'b1;
      end
      KIND_LDA: r.exec_value = wrap_to_width(a + b);
      KIND_LDC: begin
        r.exec_value = a;
        r.writeback  = 1'b1;
      end
      KIND_BEQ: begin
        if (a == b) begin
          r.exec_value = wrap_to_width(it.dest);
          r.taken      = 1'b1;
        end else begin
          r.exec_value = wrap_to_width(it.instr_pc + 64'd1);
        end
      end
      KIND_JMP: begin
        r.exec_value = a;
        r.taken      = 1'b1;
      end
      KIND_JMPR: begin
        r.exec_value = wrap_to_width(a + b);
        r.taken      = 1'b1;
      end
      KIND_STA: r.exec_value = wrap_to_width(wrap_to_width(it.dest) + b);
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    if (errors_o < MAX_PRINTED)
      $display("[%0t] MISMATCH %s: got %h, predicted %h", $realtime, what, got, exp_val);
    errors_o++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] exp_val);
    if (got !== exp_val) report_mismatch(what, got, exp_val);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_q.delete();
      pending_o = 0;
    end else begin
      if (valid_i) begin
        if (result_q.size() == 0) begin
          report_mismatch("result with no instruction outstanding", res_i.exec_value, '0);
        end else begin
          want = result_q.pop_front();
          check_field("out_kind", 64'(res_i.out_kind), 64'(want.out_kind));
          check_field("out_pc", res_i.out_pc, want.out_pc);
          check_field("out_dest", res_i.out_dest, want.out_dest);
          check_field("out_a", res_i.out_a, want.out_a);
          check_field("out_b", res_i.out_b, want.out_b);
          check_field("exec_value", res_i.exec_value, want.exec_value);
          check_field("taken", 64'(res_i.taken), 64'(want.taken));
          check_field("writeback", 64'(res_i.writeback), 64'(want.writeback));
          checked_o++;
        end
      end
      if (start_i && !busy_i) result_q.push_back(execute_instr(in_i));
      pending_o = result_q.size();
    end
  end

endmodule

FILE: dv/tb_pipeline_execute_stage_unit.sv
`timescale 1ns / 1ps
// Top of the execute stage testbench: clock, reset, directed and random
// instruction stimulus, and the verdict. Depends on pes_pkg, the stage RTL
// and pes_exec_checker.
module tb_pipeline_execute_stage_unit;

  import pes_pkg::*;

  localparam int unsigned WIDTH       = 64;
  localparam int unsigned NUM_RANDOM  = 1280;
  localparam int unsigned QUIET_TAIL  = 200;
  localparam int unsigned DRAIN_WAIT  = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;

  localparam logic [3:0]  KIND_UNUSED_LO = 4'd10;
  localparam logic [3:0]  KIND_UNUSED_HI = 4'd15;
  localparam logic [63:0] S_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] S_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ONES  = '1;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start_i = 1'b0;
  logic      busy_o;
  exec_in_t  in_i = '0;
  logic      valid_o;
  exec_out_t res_o;

  int pending;
  int errors;
  int checked;
  int cycles = 0;
  int issued = 0;
  int directed = 0;
  int unused_kinds = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  pipeline_execute_stage_unit #(
    .DATA_WIDTH(WIDTH)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .in_i   (in_i),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

  pes_exec_checker #(
    .DATA_WIDTH(WIDTH)
  ) i_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_i   (busy_o),
    .in_i     (in_i),
    .valid_i  (valid_o),
    .res_i    (res_o),
    .pending_o(pending),
    .errors_o (errors),
    .checked_o(checked)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic exec_in_t make_instr(logic [3:0] kind, logic [63:0] pc,
                                          logic [63:0] dest, logic [63:0] a,
                                          logic [63:0] b);
    exec_in_t it;
    it.kind      = kind;
    it.instr_pc  = pc;
    it.dest      = dest;
    it.operand_a = a;
    it.operand_b = b;
    return it;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Mix of full-range words, small signed values and the signed extremes.
  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0, 1, 2: v = rand_word();
      3: v = 64'($signed($urandom_range(0, 16)) - 8);
      4: begin
        case ($urandom_range(0, 4))
          0: v = S_MAX;
          1: v = S_MIN;
          2: v = ONES;
          3: v = '0;
          default: v = 64'd1;
        endcase
      end
      default: v = rand_word() ^ S_MIN;
    endcase
    return v;
  endfunction

  function automatic exec_in_t rand_instr();
    exec_in_t it;
    if ($urandom_range(0, 19) == 0)
      it.kind = 4'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
    else
      it.kind = 4'($urandom_range(KIND_NOP, KIND_STA));
    it.instr_pc  = rand_operand();
    it.dest      = rand_operand();
    it.operand_a = rand_operand();
    it.operand_b = rand_operand();
    // Equal operands often enough that branches are taken and compares give zero.
    if ((it.kind == KIND_BEQ || it.kind == KIND_CMP) && $urandom_range(0, 9) < 4)
      it.operand_b = it.operand_a;
    return it;
  endfunction

  // Called at a rising edge; returns just after the edge that takes the transfer.
  task automatic issue(input exec_in_t it);
    logic was_busy;
    start_i <= 1'b1;
    in_i    <= it;
    do begin
      @(negedge clk_i);
      was_busy = busy_o;
      @(posedge clk_i);
    end while (was_busy);
    issued++;
    if (it.kind > KIND_STA) unused_kinds++;
  endtask

  task automatic idle_for(input int unsigned n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  initial begin
    exec_in_t    seq[$];
    int unsigned idle_pct;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    seq.push_back(make_instr(KIND_NOP, ONES, ONES, ONES, ONES));
    seq.push_back(make_instr(KIND_NOP, '0, '0, '0, '0));
    seq.push_back(make_instr(KIND_ADD, 64'h40, 64'd3, S_MAX, 64'd1));
    seq.push_back(make_instr(KIND_ADD, 64'h41, 64'd4, S_MIN, ONES));
    seq.push_back(make_instr(KIND_MUL, 64'h42, 64'd5, S_MIN, ONES));
    seq.push_back(make_instr(KIND_MUL, 64'h43, 64'd6, S_MAX, S_MAX));
    seq.push_back(make_instr(KIND_CMP, 64'h44, 64'd7, 64'd5, 64'd5));
    seq.push_back(make_instr(KIND_CMP, 64'h45, 64'd8, 64'd1, ONES));
    seq.push_back(make_instr(KIND_CMP, 64'h46, 64'd9, S_MIN, S_MAX));
    seq.push_back(make_instr(KIND_CMP, 64'h47, 64'd9, ONES, '0));
    seq.push_back(make_instr(KIND_LDA, 64'h48, 64'd10, S_MAX, S_MIN));
    seq.push_back(make_instr(KIND_LDC, 64'h49, 64'd11, S_MIN, '0));
    seq.push_back(make_instr(KIND_BEQ, 64'h100, S_MIN, ONES, ONES));
    seq.push_back(make_instr(KIND_BEQ, S_MAX, 64'h200, 64'd1, 64'd2));
    seq.push_back(make_instr(KIND_BEQ, ONES, ONES, '0, '0));
    seq.push_back(make_instr(KIND_JMP, 64'h4a, '0, S_MAX, 64'd7));
    seq.push_back(make_instr(KIND_JMPR, 64'h4b, '0, S_MIN, ONES));
    seq.push_back(make_instr(KIND_STA, 64'h4c, S_MAX, ONES, 64'd1));
    seq.push_back(make_instr(KIND_STA, 64'h4d, S_MIN, 64'd9, ONES));
    seq.push_back(make_instr(KIND_UNUSED_LO, 64'h4e, 64'd12, 64'd3, 64'd4));
    seq.push_back(make_instr(KIND_UNUSED_HI, ONES, ONES, ONES, ONES));
    foreach (seq[k]) issue(seq[k]);
    directed = seq.size();

    // Let the pipeline empty completely before the random part.
    wait_drained();

    idle_pct = 0;
    for (int unsigned i = 0; i < NUM_RANDOM; i++) begin
      if (i % 100 == 0) idle_pct = $urandom_range(0, 3) * 12;
      if (i == NUM_RANDOM / 2) wait_drained();
      if (i < NUM_RANDOM - QUIET_TAIL && $urandom_range(0, 99) < idle_pct)
        idle_for($urandom_range(1, 18));
      issue(rand_instr());
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    @(negedge clk_i);

    $display("Run covered %0d instructions (%0d directed, %0d with unused kinds);",
             issued, directed, unused_kinds);
    $display("%0d results compared.", checked);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches found", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
